// ===== design/utf8_to_cp437_decoder_top_macros.svh =====
// Assertion macros for the UTF-8 to CP437 decoder checker.
// Each macro expects clk and rst to be visible where it is used.
`ifndef UTF8_TO_CP437_DECODER_TOP_MACROS_SVH
`define UTF8_TO_CP437_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define U8CP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define U8CP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/u8cp_pkg.sv =====
// Shared types, constants and mapping tables for the UTF-8 to CP437 decoder.
// No dependencies.
`timescale 1ns / 1ps

package u8cp_pkg;

  localparam logic [7:0] QMARK = 8'h3F;

  // Sequence length codes: number of continuation bytes of the open sequence.
  localparam logic [1:0] LEN_2B = 2'd1;
  localparam logic [1:0] LEN_3B = 2'd2;
  localparam logic [1:0] LEN_4B = 2'd3;

  localparam logic [20:0] MIN_2B = 21'h00080;
  localparam logic [20:0] MIN_3B = 21'h00800;

  typedef struct packed {
    logic [1:0]  rem;
    logic [20:0] acc;
    logic [1:0]  len;
  } dec_state_t;

  localparam logic [7:0] LATIN_ROM [0:127] = '{
    8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
    8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
    8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
    8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
    8'h20, 8'hAD, 8'h9B, 8'h9C, 8'h3F, 8'h9D, 8'h7C, 8'h15,
    8'h22, 8'h63, 8'hA6, 8'hAE, 8'hAA, 8'h2D, 8'h52, 8'h3F,
    8'hF8, 8'hF1, 8'hFD, 8'h33, 8'h27, 8'hE6, 8'h14, 8'hFA,
    8'h2C, 8'h31, 8'hA7, 8'hAF, 8'hAC, 8'hAB, 8'h3F, 8'hA8,
    8'h41, 8'h41, 8'h41, 8'h41, 8'h8E, 8'h8F, 8'h92, 8'h80,
    8'h45, 8'h90, 8'h45, 8'h45, 8'h49, 8'h49, 8'h49, 8'h49,
    8'h44, 8'hA5, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h99, 8'h78,
    8'h4F, 8'h55, 8'h55, 8'h55, 8'h9A, 8'h59, 8'h3F, 8'hE1,
    8'h85, 8'hA0, 8'h83, 8'h61, 8'h84, 8'h86, 8'h91, 8'h87,
    8'h8A, 8'h82, 8'h88, 8'h89, 8'h8D, 8'hA1, 8'h8C, 8'h8B,
    8'h3F, 8'hA4, 8'h95, 8'hA2, 8'h93, 8'h6F, 8'h94, 8'hF6,
    8'h6F, 8'h97, 8'hA3, 8'h96, 8'h81, 8'h79, 8'h3F, 8'h98
  };

  function automatic logic [7:0] sym_glyph(input logic [20:0] u);
    logic [7:0] g;
    g = QMARK;
    if (u[20:16] == 5'd0) begin
      case (u[15:0])
        16'h2013: g = 8'h2D;
        16'h2014: g = 8'h2D;
        16'h2018: g = 8'h27;
        16'h2019: g = 8'h27;
        16'h201C: g = 8'h22;
        16'h201D: g = 8'h22;
        16'h2022: g = 8'h07;
        16'h2026: g = 8'h2E;
        16'h2039: g = 8'h3C;
        16'h203A: g = 8'h3E;
        16'h20AC: g = 8'h45;
        16'h2190: g = 8'h1B;
        16'h2191: g = 8'h18;
        16'h2192: g = 8'h1A;
        16'h2193: g = 8'h19;
        16'h2500: g = 8'hC4;
        16'h2502: g = 8'hB3;
        16'h250C: g = 8'hDA;
        16'h2510: g = 8'hBF;
        16'h2514: g = 8'hC0;
        16'h2518: g = 8'hD9;
        16'h251C: g = 8'hC3;
        16'h2524: g = 8'hB4;
        16'h252C: g = 8'hC2;
        16'h2534: g = 8'hC1;
        16'h253C: g = 8'hC5;
        16'h2550: g = 8'hCD;
        16'h2551: g = 8'hBA;
        16'h2588: g = 8'hDB;
        16'h2591: g = 8'hB0;
        16'h2592: g = 8'hB1;
        16'h2593: g = 8'hB2;
        16'h2248: g = 8'hF7;
        16'h2260: g = 8'h21;
        16'h2264: g = 8'hF3;
        16'h2265: g = 8'hF2;
        default: g = QMARK;
      endcase
    end
    return g;
  endfunction

  function automatic logic [7:0] map_point(input logic [20:0] u);
    logic [7:0] g;
    if (u[20:8] == 13'd0 && u[7]) begin
      g = LATIN_ROM[u[6:0]];
    end else begin
      g = sym_glyph(u);
    end
    return g;
  endfunction

endpackage

// ===== design/utf8_to_cp437_decoder_top.sv =====
// UTF-8 to CP437 decoder: one UTF-8 byte in per item, zero or one CP437 byte out.
// Takes one byte every cycle while in_stall is low. A byte is held in the input register at the
// edge that accepts it. Its result is written to the result register when the byte advances,
// which waits while a stalled result holds it. Lead and middle bytes of a sequence give no result.
// in_stall rises only while a result waits in the output register and out_stall is high.
// Depends on u8cp_pkg and u8cp_decode.
`timescale 1ns / 1ps

module utf8_to_cp437_decoder_top
  import u8cp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char
);

  logic       byte_valid;
  logic [7:0] byte_reg;
  dec_state_t state;
  dec_state_t state_next;
  logic       emit;
  logic [7:0] ch;
  logic       out_free;
  logic       advance;

  assign out_free = !out_valid || !out_stall;
  assign advance  = byte_valid && out_free;
  assign in_stall = byte_valid && !out_free;

  u8cp_decode u_decode (
    .cur     (state),
    .in_byte (byte_reg),
    .nxt     (state_next),
    .emit    (emit),
    .ch      (ch)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_reg <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= byte_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_char <= ch;
    end
  end

endmodule

// ===== design/u8cp_decode.sv =====
// Per-byte UTF-8 decode step: next decoder state and the optional CP437 result.
// Depends on u8cp_pkg.
`timescale 1ns / 1ps

module u8cp_decode
  import u8cp_pkg::*;
(
  input  dec_state_t cur,
  input  logic [7:0] in_byte,
  output dec_state_t nxt,
  output logic       emit,
  output logic [7:0] ch
);

  logic [20:0] acc_shift;
  logic        overlong;

  assign acc_shift = {cur.acc[14:0], in_byte[5:0]};
  assign overlong  = (cur.len == LEN_4B) ||
                     (cur.len == LEN_2B && acc_shift < MIN_2B) ||
                     (cur.len == LEN_3B && acc_shift < MIN_3B);

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    ch   = QMARK;
    if (!in_byte[7]) begin
      nxt.rem = 2'd0;
      emit    = 1'b1;
      ch      = in_byte;
    end else if (in_byte[7:6] == 2'b10) begin
      if (cur.rem == 2'd0) begin
        emit = 1'b1;
      end else begin
        nxt.acc = acc_shift;
        nxt.rem = cur.rem - 2'd1;
        if (cur.rem == 2'd1) begin
          emit = 1'b1;
          ch   = overlong ? QMARK : map_point(acc_shift);
        end
      end
    end else if (in_byte[7:5] == 3'b110) begin
      nxt.rem = LEN_2B;
      nxt.len = LEN_2B;
      nxt.acc = {16'd0, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      nxt.rem = LEN_3B;
      nxt.len = LEN_3B;
      nxt.acc = {17'd0, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      nxt.rem = LEN_4B;
      nxt.len = LEN_4B;
      nxt.acc = {18'd0, in_byte[2:0]};
    end else begin
      nxt.rem = 2'd0;
      emit    = 1'b1;
    end
  end

endmodule

// ===== design/u8cp_checker.sv =====
// Port-level checker for the UTF-8 to CP437 decoder, bound to the top level.
// Depends on utf8_to_cp437_decoder_top_macros.svh.
`timescale 1ns / 1ps
`include "utf8_to_cp437_decoder_top_macros.svh"

module u8cp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char
);

  `U8CP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_char), "stalled result item changed")
  `U8CP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled while result register free")
  `U8CP_ASSERT_NEXT(a_ascii_pass, (in_valid && !in_stall && !in_byte[7]) ##1 (!out_valid || !out_stall), out_valid && out_char == $past(in_byte, 2), "ASCII item did not pass through")
  `U8CP_ASSERT_NEXT(a_bad_lead, (in_valid && !in_stall && in_byte[7:3] == 5'h1F) ##1 (!out_valid || !out_stall), out_valid && out_char == 8'h3F, "invalid byte did not give a question mark")

endmodule

bind utf8_to_cp437_decoder_top u8cp_checker u_checker (.*);

// ===== dv/utf8_to_cp437_decoder_top_test.sv =====
// Self-checking testbench for utf8_to_cp437_decoder_top: directed and random UTF-8 byte streams
// with random idling on both channels, checked against an in-bench decoder and CP437 table.
// Depends on the RTL top level only; its decoder and tables do not use u8cp_pkg.
`timescale 1ns / 1ps

module utf8_to_cp437_decoder_top_test;

  localparam logic [7:0] QUESTION = 8'h3F;
  localparam logic [1:0] SEQ_2B = 2'd1;
  localparam logic [1:0] SEQ_3B = 2'd2;
  localparam logic [1:0] SEQ_4B = 2'd3;
  localparam logic [20:0] MIN_2B_POINT = 21'h00080;
  localparam logic [20:0] MIN_3B_POINT = 21'h00800;
  localparam int NUM_SYMBOLS = 36;
  localparam int TOTAL_BYTES = 1300;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [7:0] LATIN_GLYPHS [0:127] = '{
    8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
    8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
    8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
    8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
    8'h20, 8'hAD, 8'h9B, 8'h9C, 8'h3F, 8'h9D, 8'h7C, 8'h15,
    8'h22, 8'h63, 8'hA6, 8'hAE, 8'hAA, 8'h2D, 8'h52, 8'h3F,
    8'hF8, 8'hF1, 8'hFD, 8'h33, 8'h27, 8'hE6, 8'h14, 8'hFA,
    8'h2C, 8'h31, 8'hA7, 8'hAF, 8'hAC, 8'hAB, 8'h3F, 8'hA8,
    8'h41, 8'h41, 8'h41, 8'h41, 8'h8E, 8'h8F, 8'h92, 8'h80,
    8'h45, 8'h90, 8'h45, 8'h45, 8'h49, 8'h49, 8'h49, 8'h49,
    8'h44, 8'hA5, 8'h4F, 8'h4F, 8'h4F, 8'h4F, 8'h99, 8'h78,
    8'h4F, 8'h55, 8'h55, 8'h55, 8'h9A, 8'h59, 8'h3F, 8'hE1,
    8'h85, 8'hA0, 8'h83, 8'h61, 8'h84, 8'h86, 8'h91, 8'h87,
    8'h8A, 8'h82, 8'h88, 8'h89, 8'h8D, 8'hA1, 8'h8C, 8'h8B,
    8'h3F, 8'hA4, 8'h95, 8'hA2, 8'h93, 8'h6F, 8'h94, 8'hF6,
    8'h6F, 8'h97, 8'hA3, 8'h96, 8'h81, 8'h79, 8'h3F, 8'h98
  };

  localparam logic [15:0] SYMBOL_POINTS [0:NUM_SYMBOLS-1] = '{
    16'h2013, 16'h2014, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2026,
    16'h2039, 16'h203A, 16'h20AC, 16'h2190, 16'h2191, 16'h2192, 16'h2193, 16'h2500,
    16'h2502, 16'h250C, 16'h2510, 16'h2514, 16'h2518, 16'h251C, 16'h2524, 16'h252C,
    16'h2534, 16'h253C, 16'h2550, 16'h2551, 16'h2588, 16'h2591, 16'h2592, 16'h2593,
    16'h2248, 16'h2260, 16'h2264, 16'h2265
  };

  localparam logic [7:0] SYMBOL_GLYPHS [0:NUM_SYMBOLS-1] = '{
    8'h2D, 8'h2D, 8'h27, 8'h27, 8'h22, 8'h22, 8'h07, 8'h2E,
    8'h3C, 8'h3E, 8'h45, 8'h1B, 8'h18, 8'h1A, 8'h19, 8'hC4,
    8'hB3, 8'hDA, 8'hBF, 8'hC0, 8'hD9, 8'hC3, 8'hB4, 8'hC2,
    8'hC1, 8'hC5, 8'hCD, 8'hBA, 8'hDB, 8'hB0, 8'hB1, 8'hB2,
    8'hF7, 8'h21, 8'hF3, 8'hF2
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_char;

  logic [1:0] conts_left = 2'd0;
  logic [20:0] partial_point = 21'd0;
  logic [1:0] open_length = 2'd0;
  logic [7:0] expected_chars[$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int bytes_sent = 0;
  int chars_checked = 0;
  int fail_count = 0;
  int idle_cycles = 0;

  utf8_to_cp437_decoder_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_char(out_char)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] cp437_glyph(input logic [20:0] cp);
    logic [7:0] g;
    g = QUESTION;
    if (cp >= 21'h80 && cp <= 21'hFF) begin
      g = LATIN_GLYPHS[cp[6:0]];
    end else begin
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
        if (cp == {5'd0, SYMBOL_POINTS[i]}) begin
          g = SYMBOL_GLYPHS[i];
        end
      end
    end
    return g;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    if (!b[7]) begin
      conts_left = 2'd0;
      expected_chars.push_back(b);
    end else if (b[7:6] == 2'b10) begin
      if (conts_left == 2'd0) begin
        expected_chars.push_back(QUESTION);
      end else begin
        partial_point = {partial_point[14:0], b[5:0]};
        conts_left = conts_left - 2'd1;
        if (conts_left == 2'd0) begin
          if (open_length == SEQ_4B ||
              (open_length == SEQ_2B && partial_point < MIN_2B_POINT) ||
              (open_length == SEQ_3B && partial_point < MIN_3B_POINT)) begin
            expected_chars.push_back(QUESTION);
          end else begin
            expected_chars.push_back(cp437_glyph(partial_point));
          end
        end
      end
    end else if (b[7:5] == 3'b110) begin
      conts_left = SEQ_2B;
      open_length = SEQ_2B;
      partial_point = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      conts_left = SEQ_3B;
      open_length = SEQ_3B;
      partial_point = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      conts_left = SEQ_4B;
      open_length = SEQ_4B;
      partial_point = {18'd0, b[2:0]};
    end else begin
      conts_left = 2'd0;
      expected_chars.push_back(QUESTION);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_point3(input logic [15:0] cp);
    send_byte({4'b1110, cp[15:12]});
    send_byte({2'b10, cp[11:6]});
    send_byte({2'b10, cp[5:0]});
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic test_ascii();
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  task automatic test_latin();
    send_byte(8'hC3);
    send_byte(8'hBF);
    send_byte(8'hC2);
    send_byte(8'hA0);
  endtask

  task automatic test_symbol();
    send_point3(16'h2013);
  endtask

  task automatic test_stray_and_invalid();
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'hF8);
  endtask

  task automatic test_overlong();
    send_byte(8'hC1);
    send_byte(8'hBF);
    send_byte(8'hE0);
    send_byte(8'h9F);
    send_byte(8'hBF);
  endtask

  task automatic test_four_byte();
    send_byte(8'hF0);
    send_byte(8'h9F);
    send_byte(8'h98);
    send_byte(8'h80);
  endtask

  task automatic test_interrupted();
    send_byte(8'hE2);
    send_byte(8'h80);
    send_byte(8'h41);
    send_byte(8'hC3);
    send_point3(16'h20AC);
  endtask

  task automatic test_drain_pause();
    send_byte(8'hC3);
    send_byte(8'hA9);
    send_point3(SYMBOL_POINTS[$urandom_range(0, NUM_SYMBOLS - 1)]);
    wait_for_results();
    send_byte(8'h5A);
  endtask

  task automatic test_random_stream(input int byte_target);
    int kind;
    int steps;
    int conts;
    logic [7:0] lead;
    steps = 0;
    while (bytes_sent < byte_target) begin
      if (steps % 40 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      steps++;
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        send_byte(8'($urandom_range(0, 127)));
      end else if (kind < 45) begin
        send_byte({3'b110, 5'($urandom)});
        send_byte({2'b10, 6'($urandom)});
      end else if (kind < 60) begin
        send_byte({4'b1110, 4'($urandom)});
        send_byte({2'b10, 6'($urandom)});
        send_byte({2'b10, 6'($urandom)});
      end else if (kind < 75) begin
        send_point3(SYMBOL_POINTS[$urandom_range(0, NUM_SYMBOLS - 1)]);
      end else if (kind < 83) begin
        send_byte({5'b11110, 3'($urandom)});
        repeat (3) send_byte({2'b10, 6'($urandom)});
      end else if (kind < 91) begin
        lead = 8'($urandom_range(8'hC0, 8'hF7));
        conts = !lead[5] ? 1 : (!lead[4] ? 2 : 3);
        send_byte(lead);
        repeat ($urandom_range(0, conts - 1)) send_byte({2'b10, 6'($urandom)});
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : receiver
    int hold;
    wait (!rst);
    forever begin
      hold = rx_idle_on ? $urandom_range(0, 6) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("out_char: expected none, actual %02h", out_char);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_char !== want) begin
          $error("out_char: expected %02h, actual %02h", want, out_char);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_ascii();
    test_latin();
    test_symbol();
    test_stray_and_invalid();
    test_overlong();
    test_four_byte();
    test_interrupted();
    test_random_stream(TOTAL_BYTES / 2);
    test_drain_pause();
    test_random_stream(TOTAL_BYTES);
    wait_for_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d UTF-8 bytes and checked %0d CP437 characters, with %0d mismatches.",
             bytes_sent, chars_checked, fail_count);
    $display("Stream mixed ASCII, Latin-1, listed symbols, overlong, four-byte and broken input.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
